// ===== src/at_response_classifier_defines.svh =====
// ---------------------------------------------------------------------------
// at_response_classifier_defines
// assertion macros used by the response classifier rtl
// ---------------------------------------------------------------------------
`ifndef AT_RESPONSE_CLASSIFIER_DEFINES_SVH
`define AT_RESPONSE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("at_response_classifier: same-cycle check failed");

// next-cycle implication, checked out of reset
`define AT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("at_response_classifier: next-cycle check failed");

`endif

// ===== src/at_rc_pkg.sv =====
// ---------------------------------------------------------------------------
// at_rc_pkg
// types, codes and pattern constants of the response classifier
// ---------------------------------------------------------------------------
package at_rc_pkg;

  // longest pattern text in bytes
  localparam int unsigned PAT_MAX_LEN = 17;
  localparam int unsigned PAT_BITS    = PAT_MAX_LEN * 8;
  localparam int unsigned PAT_LEN_W   = 5;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_COLLECT = 3'd1,
    PH_SUCCESS = 3'd2,
    PH_ERROR   = 3'd3,
    PH_TIMEOUT = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_SUCC_FIRST  = 2'd0,
    REG_SUCC_SECOND = 2'd1,
    REG_TIMEOUT     = 2'd2,
    REG_CAPACITY    = 2'd3
  } reg_idx_e;

  localparam logic [3:0]  RST_SUCC_FIRST  = 4'd1;
  localparam logic [3:0]  RST_SUCC_SECOND = 4'd0;
  localparam logic [15:0] RST_TIMEOUT     = 16'd2000;
  localparam logic [9:0]  RST_CAPACITY    = 10'd768;

  typedef struct packed {
    logic [3:0]  succ_first_sel;
    logic [3:0]  succ_second_sel;
    logic [15:0] timeout_ms;
    logic [9:0]  capacity;
  } cfg_t;

  typedef struct packed {
    logic first;
    logic second;
    logic busy;
    logic err;
  } match_t;

  // result layout, status in the lowest bits
  typedef struct packed {
    logic       busy_cleared;
    logic [1:0] success_which;
    logic       byte_accepted;
    logic [9:0] captured_length;
    logic [2:0] status;
  } res_t;

  // text is right-aligned: last character in bits [7:0]
  typedef struct packed {
    logic [PAT_BITS-1:0]  text;
    logic [PAT_LEN_W-1:0] len;
  } pat_t;

  localparam pat_t PAT_BUSY  = '{text: PAT_BITS'("busy p"),            len: 5'd6};
  localparam pat_t PAT_ERROR = '{text: PAT_BITS'("ERROR"),             len: 5'd5};
  localparam pat_t PAT_FAIL  = '{text: PAT_BITS'("FAIL"),              len: 5'd4};
  localparam pat_t PAT_LINK  = '{text: PAT_BITS'("link is not valid"), len: 5'd17};

  function automatic pat_t success_pat(logic [3:0] sel);
    pat_t p;
    p = '0;
    unique case (sel)
      4'd1: begin p.text = PAT_BITS'("OK");                p.len = 5'd2;  end
      4'd2: begin p.text = PAT_BITS'("no change");         p.len = 5'd9;  end
      4'd3: begin p.text = PAT_BITS'("WIFI GOT IP");       p.len = 5'd11; end
      4'd4: begin p.text = PAT_BITS'("CONNECT");           p.len = 5'd7;  end
      4'd5: begin p.text = PAT_BITS'("ALREADY CONNECTED"); p.len = 5'd17; end
      4'd6: begin p.text = PAT_BITS'("CLOSED");            p.len = 5'd6;  end
      4'd7: begin p.text = PAT_BITS'(">");                 p.len = 5'd1;  end
      4'd8: begin p.text = PAT_BITS'("SEND OK");           p.len = 5'd7;  end
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== src/at_response_classifier.sv =====
// ---------------------------------------------------------------------------
// at_response_classifier
// classifies a modem reply byte by byte as success, error or timeout
// ---------------------------------------------------------------------------
// Input stream: tuser carries the action (start, received byte, ms tick),
// tdata the received byte. Every transaction gives exactly one result
// transaction on the output stream with the phase, the captured length and
// the per-item flags.
// An item first lands in an input register; when the result register can
// advance, the window compare, counters and phase update run in one pass
// into the result register, which drives the output stream. One item is
// taken every cycle while results are taken, set by the single compare pass.
// The state (window, fill, counts, phase) updates together with the result
// register, so back-to-back bytes see each other's effect.
// If the receiver stalls, the result register holds and the input register
// still takes one more item; with both full, s_axis_tready drops until the
// result is taken. No transaction is lost or repeated.
// Reset clears both valid flags, the phase (idle), the counters, and loads
// the register defaults (first selector OK, timeout 2000, capacity 768).
// Registers via apb at byte addresses 0, 4, 8, 12; write only while idle.
// ---------------------------------------------------------------------------
`include "at_response_classifier_defines.svh"

module at_response_classifier #(
  parameter int unsigned WINDOW_LEN = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [12:3] captured_length, [13] byte_accepted,
  // [15:14] success_which, [16] busy_cleared, [23:17] zero
  output logic [23:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned WIN_W  = WINDOW_LEN * 8;

  at_rc_pkg::cfg_t   cfg;
  at_rc_pkg::match_t match;

  // input register
  logic        in_valid_q;
  logic [1:0]  in_action_q;
  logic [7:0]  in_byte_q;

  // result register
  logic            out_valid_q;
  at_rc_pkg::res_t res_q, res_d;

  // block state
  logic [WIN_W-1:0]  window_q, window_d, window_shift;
  logic [FILL_W-1:0] fill_q, fill_d, fill_inc;
  logic [9:0]        count_q, count_d;
  logic [15:0]       elapsed_q, elapsed_d, elapsed_inc;
  at_rc_pkg::phase_e phase_q, phase_d;

  logic advance, proc, in_fire;

  at_rc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign window_shift = {window_q[WIN_W-9:0], in_byte_q};
  assign fill_inc     = (fill_q == FILL_W'(WINDOW_LEN)) ? fill_q : fill_q + FILL_W'(1);
  assign elapsed_inc  = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

  at_rc_match #(
    .WINDOW_LEN (WINDOW_LEN),
    .FILL_W     (FILL_W)
  ) u_match (
    .window_i          (window_shift),
    .fill_i            (fill_inc),
    .succ_first_sel_i  (cfg.succ_first_sel),
    .succ_second_sel_i (cfg.succ_second_sel),
    .match_o           (match)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    window_d  = window_q;
    fill_d    = fill_q;
    count_d   = count_q;
    elapsed_d = elapsed_q;
    phase_d   = phase_q;
    res_d     = '0;
    case (in_action_q)
      at_rc_pkg::ACT_START: begin
        window_d  = '0;
        fill_d    = '0;
        count_d   = '0;
        elapsed_d = '0;
        phase_d   = (cfg.timeout_ms == 16'd0) ? at_rc_pkg::PH_TIMEOUT : at_rc_pkg::PH_COLLECT;
      end
      at_rc_pkg::ACT_BYTE: begin
        if (phase_q == at_rc_pkg::PH_COLLECT && count_q < cfg.capacity) begin
          res_d.byte_accepted = 1'b1;
          window_d = window_shift;
          fill_d   = fill_inc;
          count_d  = count_q + 10'd1;
          if (match.first) begin
            res_d.success_which = 2'd1;
            phase_d = at_rc_pkg::PH_SUCCESS;
          end else if (match.second) begin
            res_d.success_which = 2'd2;
            phase_d = at_rc_pkg::PH_SUCCESS;
          end else if (match.busy) begin
            // busy notice: drop what was collected and keep listening
            res_d.busy_cleared = 1'b1;
            window_d = '0;
            fill_d   = '0;
            count_d  = '0;
          end else if (match.err) begin
            phase_d = at_rc_pkg::PH_ERROR;
          end
        end
      end
      at_rc_pkg::ACT_TICK: begin
        if (phase_q == at_rc_pkg::PH_COLLECT) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= cfg.timeout_ms) begin
            phase_d = at_rc_pkg::PH_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
    res_d.status          = phase_d;
    res_d.captured_length = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      count_q     <= '0;
      elapsed_q   <= '0;
      phase_q     <= at_rc_pkg::PH_IDLE;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (proc) begin
        fill_q    <= fill_d;
        count_q   <= count_d;
        elapsed_q <= elapsed_d;
        phase_q   <= phase_d;
      end
    end
  end

  // payload registers, bytes beyond the fill are never compared
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_action_q <= s_axis_tuser;
      in_byte_q   <= s_axis_tdata;
    end
    if (proc) begin
      window_q <= window_d;
      res_q    <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q};

  `AT_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FILL_W'(WINDOW_LEN))
  `AT_ASSERT_NOW(a_success_phase, clk_i, rst_ni, out_valid_q && res_q.success_which != 2'd0,
                 res_q.status == at_rc_pkg::PH_SUCCESS)
  `AT_ASSERT_NOW(a_accept_counts, clk_i, rst_ni,
                 out_valid_q && res_q.byte_accepted && !res_q.busy_cleared,
                 res_q.captured_length != 10'd0)
  `AT_ASSERT_NEXT(a_idle_no_tick, clk_i, rst_ni,
                  proc && in_action_q != at_rc_pkg::ACT_START && phase_q != at_rc_pkg::PH_COLLECT,
                  $stable(elapsed_q) && $stable(count_q))

endmodule

// ===== src/at_rc_cfg.sv =====
// ---------------------------------------------------------------------------
// at_rc_cfg
// apb register file for selectors, timeout and capacity
// ---------------------------------------------------------------------------
module at_rc_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output at_rc_pkg::cfg_t    cfg_o
);

  at_rc_pkg::cfg_t cfg_q, cfg_d;
  logic            wr_en;
  logic [1:0]      idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        at_rc_pkg::REG_SUCC_FIRST:  cfg_d.succ_first_sel  = pwdata[3:0];
        at_rc_pkg::REG_SUCC_SECOND: cfg_d.succ_second_sel = pwdata[3:0];
        at_rc_pkg::REG_TIMEOUT:     cfg_d.timeout_ms      = pwdata[15:0];
        at_rc_pkg::REG_CAPACITY:    cfg_d.capacity        = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      at_rc_pkg::REG_SUCC_FIRST:  prdata = {28'd0, cfg_q.succ_first_sel};
      at_rc_pkg::REG_SUCC_SECOND: prdata = {28'd0, cfg_q.succ_second_sel};
      at_rc_pkg::REG_TIMEOUT:     prdata = {16'd0, cfg_q.timeout_ms};
      at_rc_pkg::REG_CAPACITY:    prdata = {22'd0, cfg_q.capacity};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.succ_first_sel  <= at_rc_pkg::RST_SUCC_FIRST;
      cfg_q.succ_second_sel <= at_rc_pkg::RST_SUCC_SECOND;
      cfg_q.timeout_ms      <= at_rc_pkg::RST_TIMEOUT;
      cfg_q.capacity        <= at_rc_pkg::RST_CAPACITY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/at_rc_match.sv =====
// ---------------------------------------------------------------------------
// at_rc_match
// parallel tail compare of the byte window against all patterns
// ---------------------------------------------------------------------------
module at_rc_match #(
  parameter int unsigned WINDOW_LEN = 17,
  parameter int unsigned FILL_W     = $clog2(WINDOW_LEN + 1)
) (
  input  logic [WINDOW_LEN*8-1:0] window_i,   // newest byte in [7:0]
  input  logic [FILL_W-1:0]       fill_i,
  input  logic [3:0]              succ_first_sel_i,
  input  logic [3:0]              succ_second_sel_i,
  output at_rc_pkg::match_t       match_o
);

  logic [at_rc_pkg::PAT_BITS-1:0] win_ext;

  // shorter windows pad with zeros; the fill check keeps the pad from matching
  assign win_ext = at_rc_pkg::PAT_BITS'(window_i);

  function automatic logic tail_hit(at_rc_pkg::pat_t p);
    logic hit;
    hit = (p.len != '0) && (6'(p.len) <= 6'(fill_i));
    for (int k = 0; k < at_rc_pkg::PAT_MAX_LEN; k++) begin
      if ((at_rc_pkg::PAT_LEN_W'(k) < p.len) && (win_ext[8*k +: 8] != p.text[8*k +: 8])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  always_comb begin
    match_o.first  = tail_hit(at_rc_pkg::success_pat(succ_first_sel_i));
    match_o.second = tail_hit(at_rc_pkg::success_pat(succ_second_sel_i));
    match_o.busy   = tail_hit(at_rc_pkg::PAT_BUSY);
    match_o.err    = tail_hit(at_rc_pkg::PAT_ERROR) | tail_hit(at_rc_pkg::PAT_FAIL)
                   | tail_hit(at_rc_pkg::PAT_LINK);
  end

endmodule

// ===== tb/at_response_classifier_tb.sv =====
// ---------------------------------------------------------------------------
// at_response_classifier_tb
// self-checking bench for the modem reply classifier: a directed table of
// starts, bytes and ticks, then randomized replies built from the success,
// busy and error strings under changing register settings. Every input
// transaction is run through a local classifier model and the result stream
// is compared field by field, with bursty input and a stalling receiver.
// ---------------------------------------------------------------------------
module at_response_classifier_tb;

  localparam int unsigned WIN_LEN     = 17;
  localparam int unsigned ITEM_GOAL   = 1200;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [1:0]  HIT_NONE    = 2'd0;
  localparam logic [1:0]  HIT_FIRST   = 2'd1;
  localparam logic [1:0]  HIT_SECOND  = 2'd2;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  at_response_classifier u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),   // [7:0] rx_byte
    .s_axis_tuser  (s_user),   // [1:0] action
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    // [2:0] status, [12:3] captured_length, [13] byte_accepted,
    // [15:14] success_which, [16] busy_cleared, [23:17] zero
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // classifier model state
  logic [3:0]  cfg_first;
  logic [3:0]  cfg_second;
  logic [15:0] cfg_timeout;
  logic [9:0]  cfg_capacity;
  logic [7:0]  hist [WIN_LEN];
  int unsigned hist_fill;
  logic [9:0]  byte_count;
  logic [15:0] elapsed;
  at_rc_pkg::phase_e cur_phase;

  at_rc_pkg::res_t pending_results [$];

  typedef struct {
    bit                  is_cfg;
    at_rc_pkg::reg_idx_e idx;
    logic [31:0]         val;
    logic [1:0]          act;
    logic [7:0]          data;
    bit                  typed;
    at_rc_pkg::res_t     want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  int     errors       = 0;
  int     items_sent   = 0;
  int     items_live   = 0;
  int     results_seen = 0;
  int     cfg_phases   = 0;
  int     burst_left   = 0;
  int     cycle_cnt    = 0;
  bit     hold_req     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------- classifier model ----------------

  function automatic string success_text(input logic [3:0] sel);
    case (sel)
      4'd1:    return "OK";
      4'd2:    return "no change";
      4'd3:    return "WIFI GOT IP";
      4'd4:    return "CONNECT";
      4'd5:    return "ALREADY CONNECTED";
      4'd6:    return "CLOSED";
      4'd7:    return ">";
      4'd8:    return "SEND OK";
      default: return "";
    endcase
  endfunction

  function automatic bit tail_hit(input string p);
    int n;
    n = p.len();
    if (n == 0 || n > WIN_LEN || n > hist_fill) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (hist[WIN_LEN - n + i] != p[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_capture();
    for (int i = 0; i < WIN_LEN; i++) hist[i] = '0;
    hist_fill  = 0;
    byte_count = '0;
  endfunction

  function automatic at_rc_pkg::res_t classify_item(input logic [1:0] act,
                                                    input logic [7:0] b);
    at_rc_pkg::res_t r;
    r = '0;
    if (act == at_rc_pkg::ACT_START) begin
      clear_capture();
      elapsed   = '0;
      cur_phase = (cfg_timeout == 0) ? at_rc_pkg::PH_TIMEOUT : at_rc_pkg::PH_COLLECT;
    end else if (act == at_rc_pkg::ACT_BYTE && cur_phase == at_rc_pkg::PH_COLLECT) begin
      if (byte_count < cfg_capacity) begin
        r.byte_accepted = 1'b1;
        for (int i = 0; i < WIN_LEN - 1; i++) hist[i] = hist[i + 1];
        hist[WIN_LEN - 1] = b;
        if (hist_fill < WIN_LEN) hist_fill++;
        byte_count++;
        if (tail_hit(success_text(cfg_first))) begin
          r.success_which = HIT_FIRST;
          cur_phase = at_rc_pkg::PH_SUCCESS;
        end else if (tail_hit(success_text(cfg_second))) begin
          r.success_which = HIT_SECOND;
          cur_phase = at_rc_pkg::PH_SUCCESS;
        end else if (tail_hit("busy p")) begin
          r.busy_cleared = 1'b1;
          clear_capture();
        end else if (tail_hit("ERROR") || tail_hit("FAIL") || tail_hit("link is not valid")) begin
          cur_phase = at_rc_pkg::PH_ERROR;
        end
      end
    end else if (act == at_rc_pkg::ACT_TICK && cur_phase == at_rc_pkg::PH_COLLECT) begin
      if (elapsed < ELAPSED_MAX) elapsed++;
      if (elapsed >= cfg_timeout) cur_phase = at_rc_pkg::PH_TIMEOUT;
    end
    r.status          = cur_phase;
    r.captured_length = byte_count;
    return r;
  endfunction

  // ---------------- drivers ----------------

  task automatic send_item(input logic [1:0] act, input logic [7:0] b, input bit typed,
                           input at_rc_pkg::res_t want);
    at_rc_pkg::res_t pred;
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    items_sent++;
    if (act == at_rc_pkg::ACT_START || (cur_phase == at_rc_pkg::PH_COLLECT &&
        (act == at_rc_pkg::ACT_BYTE || act == at_rc_pkg::ACT_TICK)))
      items_live++;
    pred = classify_item(act, b);
    pending_results.push_back(typed ? want : pred);
  endtask

  // stop offering, wait for every result, then let the pipeline settle
  task automatic quiesce(input int settle);
    @(negedge clk_i);
    s_valid   <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_reg(input at_rc_pkg::reg_idx_e idx, input logic [31:0] val);
    logic [31:0] rd;
    quiesce(4);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      at_rc_pkg::REG_SUCC_FIRST:  cfg_first    = val[3:0];
      at_rc_pkg::REG_SUCC_SECOND: cfg_second   = val[3:0];
      at_rc_pkg::REG_TIMEOUT:     cfg_timeout  = val[15:0];
      at_rc_pkg::REG_CAPACITY:    cfg_capacity = val[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // read back
    @(negedge clk_i);
    psel    <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) begin
      $error("register %0d readback: expected %0h, got %0h", idx, val, rd);
      errors++;
    end
  endtask

  // ---------------- directed rows ----------------

  task automatic add_item(input logic [1:0] act, input logic [7:0] b);
    dir_row_t r;
    r.is_cfg = 1'b0; r.idx = at_rc_pkg::REG_SUCC_FIRST; r.val = '0;
    r.act = act; r.data = b; r.typed = 1'b0; r.want = '0;
    dir_rows.push_back(r);
  endtask

  task automatic add_check(input logic [1:0] act, input logic [7:0] b,
                           input at_rc_pkg::phase_e st, input logic [9:0] len,
                           input logic acc, input logic [1:0] which, input logic busy);
    dir_row_t r;
    r.is_cfg = 1'b0; r.idx = at_rc_pkg::REG_SUCC_FIRST; r.val = '0;
    r.act = act; r.data = b; r.typed = 1'b1;
    r.want = '{busy_cleared: busy, success_which: which, byte_accepted: acc,
               captured_length: len, status: st};
    dir_rows.push_back(r);
  endtask

  task automatic add_cfg(input at_rc_pkg::reg_idx_e idx, input logic [31:0] val);
    dir_row_t r;
    r.is_cfg = 1'b1; r.idx = idx; r.val = val;
    r.act = at_rc_pkg::ACT_START; r.data = '0; r.typed = 1'b0; r.want = '0;
    dir_rows.push_back(r);
  endtask

  // ---------------- random replies ----------------

  function automatic string pick_pattern();
    int k;
    string s;
    k = $urandom_range(0, 15);
    case (k)
      12, 13:  s = success_text(cfg_first);
      14, 15:  s = success_text(cfg_second);
      8:       s = "busy p";
      9:       s = "ERROR";
      10:      s = "FAIL";
      11:      s = "link is not valid";
      default: s = success_text(4'(k + 1));
    endcase
    if (s.len() == 0) s = "OK";
    return s;
  endfunction

  function automatic logic [7:0] pick_char();
    string s;
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    s = pick_pattern();
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [3:0] pick_sel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 4'($urandom_range(1, 8));
    if (r == 7) return 4'd0;
    return 4'($urandom_range(9, 15));
  endfunction

  task automatic run_replies(input int target);
    int    start_cnt;
    int    n;
    string s;
    start_cnt = items_sent;
    if ($urandom_range(0, 9) != 0)
      send_item(at_rc_pkg::ACT_START, 8'($urandom_range(0, 255)), 1'b0, '0);
    while (items_sent - start_cnt < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 4)) send_item(at_rc_pkg::ACT_BYTE, pick_char(), 1'b0, '0);
        end
        3, 4, 9: begin
          s = pick_pattern();
          for (int i = 0; i < s.len(); i++) send_item(at_rc_pkg::ACT_BYTE, s[i], 1'b0, '0);
        end
        5: begin
          // truncated pattern
          s = pick_pattern();
          n = (s.len() > 1) ? $urandom_range(1, s.len() - 1) : 1;
          for (int i = 0; i < n; i++) send_item(at_rc_pkg::ACT_BYTE, s[i], 1'b0, '0);
        end
        6: begin
          repeat ($urandom_range(1, 4))
            send_item(at_rc_pkg::ACT_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
        7: begin
          send_item(($urandom_range(0, 1) == 0) ? ACT_UNUSED : at_rc_pkg::ACT_BYTE,
                    8'($urandom_range(0, 255)), 1'b0, '0);
        end
        default: send_item(at_rc_pkg::ACT_START, 8'($urandom_range(0, 255)), 1'b0, '0);
      endcase
    end
  endtask

  // ---------------- receiver ----------------

  initial begin : receiver
    int run_left;
    int mode;
    run_left = 0;
    mode     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // long hold-off so the input side backs up
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = $urandom_range(20, 200);
        end
        run_left--;
        case (mode)
          0:       m_ready <= 1'b1;
          1:       m_ready <= 1'($urandom_range(0, 1));
          2:       m_ready <= ($urandom_range(0, 3) != 0);
          default: m_ready <= ((cycle_cnt % 5) < 3);
        endcase
      end
    end
  end

  // ---------------- result checker ----------------

  always @(posedge clk_i) begin : result_check
    at_rc_pkg::res_t want;
    at_rc_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      got = at_rc_pkg::res_t'(m_axis_tdata[16:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.captured_length !== want.captured_length) begin
          $error("captured_length: expected %0d, got %0d", want.captured_length,
                 got.captured_length);
          errors++;
        end
        if (got.byte_accepted !== want.byte_accepted) begin
          $error("byte_accepted: expected %0d, got %0d", want.byte_accepted, got.byte_accepted);
          errors++;
        end
        if (got.success_which !== want.success_which) begin
          $error("success_which: expected %0d, got %0d", want.success_which, got.success_which);
          errors++;
        end
        if (got.busy_cleared !== want.busy_cleared) begin
          $error("busy_cleared: expected %0d, got %0d", want.busy_cleared, got.busy_cleared);
          errors++;
        end
        if (m_axis_tdata[23:17] !== '0) begin
          $error("tdata padding: expected 0, got %0h", m_axis_tdata[23:17]);
          errors++;
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i) cycle_cnt++;
    $display("tb: failure");
    $finish;
  end

  // ---------------- main sequence ----------------

  initial begin : main_seq
    logic [3:0]  s1;
    logic [3:0]  s2;
    logic [15:0] tmo;
    logic [9:0]  cap;
    int          p;
    int          r;

    cfg_first    = at_rc_pkg::RST_SUCC_FIRST;
    cfg_second   = at_rc_pkg::RST_SUCC_SECOND;
    cfg_timeout  = at_rc_pkg::RST_TIMEOUT;
    cfg_capacity = at_rc_pkg::RST_CAPACITY;
    clear_capture();
    elapsed   = '0;
    cur_phase = at_rc_pkg::PH_IDLE;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ignored while idle, then a plain OK reply under reset defaults
    add_check(at_rc_pkg::ACT_BYTE, 8'hFF, at_rc_pkg::PH_IDLE, 10'd0, 1'b0, HIT_NONE, 1'b0);
    add_check(at_rc_pkg::ACT_TICK, 8'h00, at_rc_pkg::PH_IDLE, 10'd0, 1'b0, HIT_NONE, 1'b0);
    add_check(ACT_UNUSED, 8'hFF, at_rc_pkg::PH_IDLE, 10'd0, 1'b0, HIT_NONE, 1'b0);
    add_check(at_rc_pkg::ACT_START, 8'h00, at_rc_pkg::PH_COLLECT, 10'd0, 1'b0, HIT_NONE, 1'b0);
    add_item(at_rc_pkg::ACT_BYTE, "O");
    add_check(at_rc_pkg::ACT_BYTE, "K", at_rc_pkg::PH_SUCCESS, 10'd2, 1'b1, HIT_FIRST, 1'b0);
    add_check(at_rc_pkg::ACT_BYTE, 8'h00, at_rc_pkg::PH_SUCCESS, 10'd2, 1'b0, HIT_NONE, 1'b0);
    // busy notice clears and collection continues, then error
    add_check(at_rc_pkg::ACT_START, 8'hFF, at_rc_pkg::PH_COLLECT, 10'd0, 1'b0, HIT_NONE, 1'b0);
    add_item(at_rc_pkg::ACT_BYTE, "b");
    add_item(at_rc_pkg::ACT_BYTE, "u");
    add_item(at_rc_pkg::ACT_BYTE, "s");
    add_item(at_rc_pkg::ACT_BYTE, "y");
    add_item(at_rc_pkg::ACT_BYTE, " ");
    add_check(at_rc_pkg::ACT_BYTE, "p", at_rc_pkg::PH_COLLECT, 10'd0, 1'b1, HIT_NONE, 1'b1);
    add_item(at_rc_pkg::ACT_BYTE, "E");
    add_item(at_rc_pkg::ACT_BYTE, "R");
    add_item(at_rc_pkg::ACT_BYTE, "R");
    add_item(at_rc_pkg::ACT_BYTE, "O");
    add_check(at_rc_pkg::ACT_BYTE, "R", at_rc_pkg::PH_ERROR, 10'd5, 1'b1, HIT_NONE, 1'b0);
    // zero capacity: nothing accepted
    add_cfg(at_rc_pkg::REG_CAPACITY, 32'd0);
    add_check(at_rc_pkg::ACT_START, 8'hA5, at_rc_pkg::PH_COLLECT, 10'd0, 1'b0, HIT_NONE, 1'b0);
    add_check(at_rc_pkg::ACT_BYTE, "O", at_rc_pkg::PH_COLLECT, 10'd0, 1'b0, HIT_NONE, 1'b0);
    // zero timeout ends at the start, and a tick then changes nothing
    add_cfg(at_rc_pkg::REG_TIMEOUT, 32'd0);
    add_check(at_rc_pkg::ACT_START, 8'h5A, at_rc_pkg::PH_TIMEOUT, 10'd0, 1'b0, HIT_NONE, 1'b0);
    add_check(at_rc_pkg::ACT_TICK, 8'hFF, at_rc_pkg::PH_TIMEOUT, 10'd0, 1'b0, HIT_NONE, 1'b0);
    // meaningless first selector, second selector hits
    add_cfg(at_rc_pkg::REG_TIMEOUT, 32'd2);
    add_cfg(at_rc_pkg::REG_CAPACITY, 32'd1023);
    add_cfg(at_rc_pkg::REG_SUCC_SECOND, 32'd7);
    add_cfg(at_rc_pkg::REG_SUCC_FIRST, 32'd12);
    add_check(at_rc_pkg::ACT_START, 8'h00, at_rc_pkg::PH_COLLECT, 10'd0, 1'b0, HIT_NONE, 1'b0);
    add_check(at_rc_pkg::ACT_BYTE, ">", at_rc_pkg::PH_SUCCESS, 10'd1, 1'b1, HIT_SECOND, 1'b0);
    add_item(at_rc_pkg::ACT_START, 8'h00);
    add_item(at_rc_pkg::ACT_TICK, 8'h00);
    add_check(at_rc_pkg::ACT_TICK, 8'h00, at_rc_pkg::PH_TIMEOUT, 10'd0, 1'b0, HIT_NONE, 1'b0);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) set_reg(dir_rows[k].idx, dir_rows[k].val);
      else send_item(dir_rows[k].act, dir_rows[k].data, dir_rows[k].typed, dir_rows[k].want);
    end

    p = 0;
    while (items_sent < ITEM_GOAL) begin
      case (p)
        0: begin s1 = 4'd0; s2 = 4'd15; tmo = 16'hFFFF; cap = 10'd1023; end
        1: begin s1 = 4'd8; s2 = 4'd5;  tmo = 16'd0;    cap = 10'd0;    end
        2: begin s1 = 4'd9; s2 = 4'd7;  tmo = 16'd1;    cap = 10'd1;    end
        default: begin
          s1 = pick_sel();
          s2 = pick_sel();
          r  = $urandom_range(0, 9);
          tmo = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd2000
                : 16'($urandom_range(1, 40));
          r  = $urandom_range(0, 9);
          cap = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : (r == 2) ? 10'd768
                : 10'($urandom_range(1, 40));
        end
      endcase
      // no start is forced, so a running collection may see a lowered timeout
      set_reg(at_rc_pkg::REG_SUCC_FIRST, {28'd0, s1});
      set_reg(at_rc_pkg::REG_SUCC_SECOND, {28'd0, s2});
      set_reg(at_rc_pkg::REG_TIMEOUT, {16'd0, tmo});
      set_reg(at_rc_pkg::REG_CAPACITY, {22'd0, cap});
      cfg_phases++;
      if (p == 3 || p == 17) begin
        hold_req = 1'b1;
        run_replies(80);
      end else begin
        run_replies($urandom_range(10, 50));
      end
      p++;
    end

    quiesce(8);

    $display("ran %0d input transactions (%0d that changed state) over %0d register settings",
             items_sent, items_live, cfg_phases);
    $display("compared %0d result transactions, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
